FILE: rtl/swm_pkg.sv
// Shared constants and types of the sliding window maximum block.
// No dependencies; used by swm_cell and sliding_window_maximum.
`default_nettype none

package swm_pkg;

  // largest supported window and sample width
  localparam int unsigned WindowMax  = 64;
  localparam int unsigned DataWidth  = 16;
  // width of the window size register
  localparam int unsigned CfgWidth   = 7;
  // cells in the chain: one per window length from 2 up to WindowMax
  localparam int unsigned NumCells   = WindowMax - 1;
  // index of one cell
  localparam int unsigned IdxWidth   = (NumCells > 1) ? $clog2(NumCells) : 1;
  // count of samples seen, up to WindowMax
  localparam int unsigned CountWidth = $clog2(WindowMax + 1);

  typedef logic signed [DataWidth-1:0] sample_t;
  typedef logic [CfgWidth-1:0]         win_t;
  typedef logic [IdxWidth-1:0]         idx_t;
  typedef logic [CountWidth-1:0]       count_t;

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// One cell of the running maximum chain: holds the maximum of a fixed
// number of the most recent samples. Depends on swm_pkg.
`default_nettype none

module swm_cell import swm_pkg::*; (
  input  logic    clk_i,
  input  logic    en_i,
  input  sample_t sample_i,
  input  sample_t prev_i,
  output sample_t max_o
);

  sample_t max_d, max_q;

  // neighbour's span extended by the new sample
  always_comb begin
    max_d = (prev_i > sample_i) ? prev_i : sample_i;
  end

  // payload register, loaded when an item is taken
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_maximum.sv
// Top level of the sliding window maximum block: window size register,
// cell chain, sample count and output register. Depends on swm_pkg, swm_cell.
`default_nettype none

// Sliding window maximum over a stream of signed 16-bit samples. One item is
// taken every clock cycle while the result side keeps up; a new item enters
// only while the output register is empty or its result is taken in the same
// cycle. Each result is registered and appears in the cycle after its item
// is taken; a waiting result holds off the input until it is taken.
// A chain of 63 cells holds, in cell i, the maximum of the latest i+1 samples;
// each item shifts every span one step down the chain with one compare per
// cell. The result for window k is the new sample compared with cell k-2.
// No result is given until k samples have arrived since the last restart.
// window_size 0 acts as 1, values above 64 act as 64; write it only while idle.

module sliding_window_maximum import swm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  // window size register
  input  logic    cfg_valid_i,
  output logic    cfg_ready_o,
  input  win_t    window_size_i,
  // sample items
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sample_t sample_i,
  input  logic    restart_i,
  // result items
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sample_t window_max_o
);

  win_t    window_size_q;
  win_t    win_eff;
  idx_t    tap_idx;
  count_t  seen_q, seen_d, seen_base;
  logic    out_valid_q, out_valid_d;
  sample_t window_max_q, window_max_d;
  sample_t tap_max;
  logic    accept;
  sample_t cell_max [NumCells];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= win_t'(1);
    end else if (cfg_valid_i) begin
      window_size_q <= window_size_i;
    end
  end

  // clamp to the supported range
  always_comb begin
    if (window_size_q == '0) begin
      win_eff = win_t'(1);
    end else if (window_size_q > win_t'(WindowMax)) begin
      win_eff = win_t'(WindowMax);
    end else begin
      win_eff = window_size_q;
    end
  end

  // chain of cells; cell 0 sees the new sample as its neighbour
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    sample_t prev;
    if (i == 0) begin : g_head
      assign prev = sample_i;
    end else begin : g_body
      assign prev = cell_max[i-1];
    end
    swm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .sample_i (sample_i),
      .prev_i   (prev),
      .max_o    (cell_max[i])
    );
  end

  // tap for the current window and the result value
  always_comb begin
    tap_idx = idx_t'(win_eff - win_t'(2));
    tap_max = cell_max[tap_idx];
    if (win_eff == win_t'(1)) begin
      window_max_d = sample_i;
    end else begin
      window_max_d = (tap_max > sample_i) ? tap_max : sample_i;
    end
  end

  // samples since restart, saturating at the window
  always_comb begin
    seen_base = restart_i ? '0 : seen_q;
    if (seen_base >= count_t'(win_eff)) begin
      seen_d = count_t'(win_eff);
    end else begin
      seen_d = seen_base + count_t'(1);
    end
  end

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      out_valid_d = (seen_d >= count_t'(win_eff));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        seen_q <= seen_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      window_max_q <= window_max_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

endmodule

`default_nettype wire
